### hdl/ttia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttia_pkg: shared definitions for the text to integer converter
// Widths, character codes, register indexes and the operation record that
// the front end hands to the back end.
// ----------------------------------------------------------------------------
package ttia_pkg;

  localparam int MAX_SYMBOLS_DEFAULT = 16;
  localparam int SYMBOL_SLOTS        = 16;
  localparam int CHAR_W              = 8;
  localparam int SYMBOLS_W           = SYMBOL_SLOTS * CHAR_W;
  localparam int DIGIT_W             = 4;
  localparam int BASE_W              = 5;
  localparam int ACC_W               = 64;
  localparam int VALUE_W             = 32;
  localparam int CFG_INDEX_W         = 2;
  localparam int CFG_DATA_W          = 64;
  localparam int QUEUE_DEPTH         = 2;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // Lowest 64-bit pattern that still reads as a value of at least INT_MIN.
  localparam logic [ACC_W-1:0] INT_MIN_EXT = 64'hFFFF_FFFF_8000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_BASE_LENGTH  = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_DIGIT = 2'd0,
    OP_SIGN  = 2'd1,
    OP_EMIT  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic                 clear;
    logic                 negative;
    logic [DIGIT_W-1:0]   digit;
  } op_t;

endpackage

### hdl/ttia_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttia_if: channel interfaces of the text to integer converter
// Character input channel, configuration write channel and result channel,
// each with valid and ready.
// ----------------------------------------------------------------------------
interface ttia_char_if;
  logic                         valid;
  logic                         ready;
  logic [ttia_pkg::CHAR_W-1:0]  character;
  logic                         first_of_string;

  modport source (output valid, character, first_of_string, input ready);
  modport sink   (input valid, character, first_of_string, output ready);
endinterface

interface ttia_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ttia_pkg::CFG_INDEX_W-1:0]  index;
  logic [ttia_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ttia_value_if;
  logic                                valid;
  logic                                ready;
  logic signed [ttia_pkg::VALUE_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

### hdl/ttia_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttia_front: character classifier
// Tracks the parse phase, matches each character against the digit alphabet
// and pushes digit, sign and emit operations into the queue.
// ----------------------------------------------------------------------------
module ttia_front #(
  parameter int MAX_SYMBOLS = ttia_pkg::MAX_SYMBOLS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  ttia_char_if.sink                         text,
  input  logic [ttia_pkg::BASE_W-1:0]       used_symbols,
  input  logic [ttia_pkg::SYMBOLS_W-1:0]    symbols,
  input  logic                              queue_full,
  output logic                              push,
  output ttia_pkg::op_t                     push_op
);

  typedef enum logic [1:0] {
    PH_LEADING,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                          phase;
  phase_t                          phase_eff;
  phase_t                          phase_next;
  logic                            pending_clear;
  logic                            accept;
  logic                            want_push;
  logic                            hit;
  logic [ttia_pkg::DIGIT_W-1:0]    digit;
  logic                            is_space;
  logic                            is_sign;

  assign text.ready = !queue_full;
  assign accept     = text.valid && text.ready;
  assign push       = accept && want_push;

  // Parallel compare against every slot; scanning downwards lets the lowest
  // matching index win.
  always_comb begin
    hit   = 1'b0;
    digit = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if ((i < int'(used_symbols)) &&
          (symbols[i*ttia_pkg::CHAR_W +: ttia_pkg::CHAR_W] != '0) &&
          (symbols[i*ttia_pkg::CHAR_W +: ttia_pkg::CHAR_W] == text.character)) begin
        hit   = 1'b1;
        digit = ttia_pkg::DIGIT_W'(i);
      end
    end
  end

  always_comb begin
    is_space = (text.character == ttia_pkg::CHAR_SPACE) ||
               (text.character inside {[ttia_pkg::CHAR_TAB:ttia_pkg::CHAR_CR]});
    is_sign  = (text.character == ttia_pkg::CHAR_PLUS) ||
               (text.character == ttia_pkg::CHAR_MINUS);
    phase_eff = text.first_of_string ? PH_LEADING : phase;

    push_op.kind     = ttia_pkg::OP_EMIT;
    push_op.clear    = text.first_of_string || pending_clear;
    push_op.negative = (text.character == ttia_pkg::CHAR_MINUS);
    push_op.digit    = digit;
    want_push        = 1'b0;
    phase_next       = phase_eff;

    case (phase_eff)
      PH_LEADING: begin
        if (is_space) begin
          want_push = 1'b0;
        end else if (is_sign) begin
          push_op.kind = ttia_pkg::OP_SIGN;
          want_push    = 1'b1;
          phase_next   = PH_DIGITS;
        end else if (hit) begin
          push_op.kind = ttia_pkg::OP_DIGIT;
          want_push    = 1'b1;
          phase_next   = PH_DIGITS;
        end else begin
          want_push    = 1'b1;
          phase_next   = PH_DONE;
        end
      end
      PH_DIGITS: begin
        want_push = 1'b1;
        if (hit) begin
          push_op.kind = ttia_pkg::OP_DIGIT;
        end else begin
          phase_next   = PH_DONE;
        end
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  // A restart is remembered until the first operation of the new string
  // carries it to the back end.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_DONE;
      pending_clear <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      pending_clear <= want_push ? 1'b0 : (text.first_of_string || pending_clear);
    end
  end

endmodule

### hdl/ttia_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttia_queue: operation queue
// Small first-in first-out buffer that decouples the classifier from the
// accumulator.
// ----------------------------------------------------------------------------
module ttia_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ttia_pkg::op_t  push_op,
  input  logic           pop,
  output ttia_pkg::op_t  head,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = ttia_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ttia_pkg::op_t     entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("pop from an empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNT_W'(1)))
    else $error("queue count did not follow a push");

endmodule

### hdl/ttia_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttia_back: accumulator and result stage
// Applies queued operations to the 64-bit accumulator and forms the signed
// 32-bit result in an output register.
// ----------------------------------------------------------------------------
module ttia_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ttia_pkg::op_t                 head,
  input  logic                          empty,
  input  logic [ttia_pkg::BASE_W-1:0]   used_symbols,
  output logic                          pop,
  ttia_value_if.source                  result
);

  logic [ttia_pkg::ACC_W-1:0]      accumulator;
  logic [ttia_pkg::ACC_W-1:0]      acc_base;
  logic [ttia_pkg::ACC_W-1:0]      acc_next;
  logic                            is_negative;
  logic                            neg_base;
  logic                            below_min;
  logic [ttia_pkg::VALUE_W-1:0]    final_value;
  logic                            out_valid;
  logic [ttia_pkg::VALUE_W-1:0]    out_value;
  logic                            is_emit;

  assign is_emit = (head.kind == ttia_pkg::OP_EMIT);
  // Digits and signs never wait; only a result needs room in the output register.
  assign pop     = !empty && (!is_emit || !out_valid || result.ready);

  assign acc_base = head.clear ? '0 : accumulator;
  assign neg_base = head.clear ? 1'b0 : is_negative;
  assign acc_next = ttia_pkg::ACC_W'(acc_base * ttia_pkg::ACC_W'(used_symbols)) +
                    ttia_pkg::ACC_W'(head.digit);

  always_comb begin
    below_min = acc_base[ttia_pkg::ACC_W-1] && (acc_base < ttia_pkg::INT_MIN_EXT);
    if (below_min) begin
      final_value = neg_base ? '0 : '1;
    end else if (neg_base) begin
      final_value = '0 - acc_base[ttia_pkg::VALUE_W-1:0];
    end else begin
      final_value = acc_base[ttia_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head.kind)
        ttia_pkg::OP_DIGIT: begin
          accumulator <= acc_next;
          is_negative <= neg_base;
        end
        ttia_pkg::OP_SIGN: begin
          accumulator <= acc_base;
          is_negative <= head.negative;
        end
        default: begin
          accumulator <= acc_base;
          is_negative <= neg_base;
        end
      endcase
    end
    if (pop && is_emit) begin
      out_value <= final_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && is_emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid = out_valid;
  assign result.value = out_value;

endmodule

### hdl/text_to_integer_any_base.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_integer_any_base: text to integer with a configurable alphabet
// Converts a byte stream into signed 32-bit integers, using a digit alphabet
// of up to sixteen programmable symbols.
// ----------------------------------------------------------------------------
// Usage:
//   text   : one character per transaction; first_of_string restarts parsing.
//   cfg    : register writes (0 base_length, 1 symbols_low, 2 symbols_high),
//            always ready, to be issued only while the converter is idle.
//   result : one signed value per string, at the first non-digit that is not
//            leading white space or a leading sign.
// Throughput is one character per cycle while the queue is not full. The front
// end classifies and matches each character in the cycle it is taken; the back
// end performs one 64-bit by 5-bit multiply-add per cycle while digits are
// queued. A result goes through the queue and the output register after its
// terminator is taken. When the receiver stalls, the held result blocks only
// later results; the two-entry queue then fills and text.ready falls.
// Reset clears the configuration to zero and leaves the parser waiting for a
// new string; no clearing pass is needed.
// ----------------------------------------------------------------------------
module text_to_integer_any_base #(
  parameter int MAX_SYMBOLS = ttia_pkg::MAX_SYMBOLS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  ttia_char_if.sink      text,
  ttia_cfg_if.sink       cfg,
  ttia_value_if.source   result
);

  logic [ttia_pkg::BASE_W-1:0]      base_length;
  logic [ttia_pkg::CFG_DATA_W-1:0]  symbols_low;
  logic [ttia_pkg::CFG_DATA_W-1:0]  symbols_high;
  logic [ttia_pkg::BASE_W-1:0]      used_symbols;
  logic                             push;
  ttia_pkg::op_t                    push_op;
  logic                             pop;
  ttia_pkg::op_t                    head;
  logic                             full;
  logic                             empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ttia_pkg::CFG_BASE_LENGTH:  base_length  <= cfg.data[ttia_pkg::BASE_W-1:0];
        ttia_pkg::CFG_SYMBOLS_LOW:  symbols_low  <= cfg.data;
        ttia_pkg::CFG_SYMBOLS_HIGH: symbols_high <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Lengths beyond the alphabet size act as the full alphabet.
  assign used_symbols = (base_length > ttia_pkg::BASE_W'(MAX_SYMBOLS)) ?
                        ttia_pkg::BASE_W'(MAX_SYMBOLS) : base_length;

  ttia_front #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .text         (text),
    .used_symbols (used_symbols),
    .symbols      ({symbols_high, symbols_low}),
    .queue_full   (full),
    .push         (push),
    .push_op      (push_op)
  );

  ttia_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  ttia_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .used_symbols (used_symbols),
    .pop          (pop),
    .result       (result)
  );

endmodule
